FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache policy package
// Shared sizes, codes, structures and helpers for the LFU cache policy unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

   // Built entry count and the widths that follow from it.
   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W      = $clog2(ENTRIES + 1);
   localparam int CAP_W      = 5;
   localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int DATA_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DATA_W-1:0] SAT_MAX        = '1;
   localparam logic [DATA_W-1:0] MISS_VALUE     = '1;
   localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);

   // Register index codes, taken from the word address.
   typedef enum logic {
      CSR_CAPACITY = 1'b0,
      CSR_NONE     = 1'b1
   } lfu_csr_type;

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } lfu_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } lfu_state_type;

   // One entry as read from the store.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] stamp;
   } lfu_entry_type;

   // Write command into the store; a write also marks the entry valid.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] stamp;
   } lfu_write_type;

   // Control of the scan unit from the sequencer.
   typedef struct packed {
      logic             clear;
      logic             step;
      logic [IDX_W-1:0] index;
   } lfu_scan_ctl_type;

   // Scan results collected over one pass.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] found_idx;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             min_found;
      logic [IDX_W-1:0] min_idx;
   } lfu_scan_type;

   // Increment that sticks at the all-ones value.
   function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
      return (v == SAT_MAX) ? v : v + DATA_W'(1);
   endfunction

endpackage

FILE: hdl/lfu_req_if.sv
// ----------------------------------------------------------------------------
// LFU request channel
// Valid/ready channel that carries one get or put request per beat.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] key;
   logic signed [31:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

FILE: hdl/lfu_rsp_if.sv
// ----------------------------------------------------------------------------
// LFU response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] read_value;
   logic               evicted;
   logic signed [31:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

FILE: hdl/lfu_entry_store.sv
// ----------------------------------------------------------------------------
// LFU entry store
// Entry registers with one read index and one write port; valid bits reset.
// ----------------------------------------------------------------------------
module lfu_entry_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lfu_pkg::IDX_W-1:0]  rd_idx,
   input  lfu_pkg::lfu_write_type     wr,
   output lfu_pkg::lfu_entry_type     rd
);
   import lfu_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [DATA_W-1:0]  key_ff   [ENTRIES];
   logic [DATA_W-1:0]  value_ff [ENTRIES];
   logic [DATA_W-1:0]  count_ff [ENTRIES];
   logic [DATA_W-1:0]  stamp_ff [ENTRIES];

   // A write always leaves the entry valid; nothing ever clears it but reset.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload fields hold no reset; they are only read behind the valid bit.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_ff[wr.idx]   <= wr.key;
         value_ff[wr.idx] <= wr.value;
         count_ff[wr.idx] <= wr.count;
         stamp_ff[wr.idx] <= wr.stamp;
      end
   end

   // Single read port shared by the scan and the update step.
   always_comb begin
      rd.valid = valid_ff[rd_idx];
      rd.key   = key_ff[rd_idx];
      rd.value = value_ff[rd_idx];
      rd.count = count_ff[rd_idx];
      rd.stamp = stamp_ff[rd_idx];
   end

endmodule

FILE: hdl/lfu_scan_unit.sv
// ----------------------------------------------------------------------------
// LFU scan unit
// Shared compare unit that looks at one entry per cycle for a key match,
// the first free slot and the least-frequently-used victim.
// ----------------------------------------------------------------------------
module lfu_scan_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  lfu_pkg::lfu_scan_ctl_type   ctl,
   input  logic [lfu_pkg::DATA_W-1:0]  lookup_key,
   input  lfu_pkg::lfu_entry_type      entry,
   output lfu_pkg::lfu_scan_type       res
);
   import lfu_pkg::*;

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  found_idx_ff, found_idx_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              min_ff, min_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;
   logic [DATA_W-1:0] min_count_ff, min_count_in;
   logic [DATA_W-1:0] min_stamp_ff, min_stamp_in;
   logic              is_match;
   logic              is_free;
   logic              is_less;

   // One entry per step: key compare, free test and (count, stamp) ordering.
   // Strict less keeps the lowest index on a full tie.
   always_comb begin
      is_match = ctl.step && entry.valid && (entry.key == lookup_key);
      is_free  = ctl.step && !entry.valid;
      is_less  = (entry.count < min_count_ff) ||
                 ((entry.count == min_count_ff) && (entry.stamp < min_stamp_ff));

      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      min_in       = min_ff;
      min_idx_in   = min_idx_ff;
      min_count_in = min_count_ff;
      min_stamp_in = min_stamp_ff;

      if (ctl.clear) begin
         found_in = 1'b0;
         free_in  = 1'b0;
         min_in   = 1'b0;
      end else begin
         if (is_match && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = ctl.index;
         end
         if (is_free && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ctl.index;
         end
         if (ctl.step && entry.valid && (!min_ff || is_less)) begin
            min_in       = 1'b1;
            min_idx_in   = ctl.index;
            min_count_in = entry.count;
            min_stamp_in = entry.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         min_ff   <= 1'b0;
      end else begin
         found_ff <= found_in;
         free_ff  <= free_in;
         min_ff   <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_count_ff <= min_count_in;
      min_stamp_ff <= min_stamp_in;
   end

   assign res.found      = found_ff;
   assign res.found_idx  = found_idx_ff;
   assign res.free_found = free_ff;
   assign res.free_idx   = free_idx_ff;
   assign res.min_found  = min_ff;
   assign res.min_idx    = min_idx_ff;

endmodule

FILE: hdl/lfu_cache_policy_unit.sv
// ----------------------------------------------------------------------------
// LFU cache policy unit
// Fully associative key/value store with least-frequently-used replacement.
//
// Usage: each beat on req_chan is a get (kind 0) or a put (kind 1) of a key
// and value. Each request yields exactly one beat on rsp_chan with the hit
// flag, the read value (all ones unless a get hits), and the evicted flag and
// key. A request is taken only while the unit is idle. It then scans all
// ENTRIES slots, one per cycle through a single compare unit, for the key,
// the first free slot and the victim (lowest count, then oldest stamp, then
// lowest slot). An update step then writes the chosen slot and loads the result;
// it waits while the output register is full. A new request is taken only once
// the unit is back in idle after the result loads, so the unit works on one
// request at a time.
// The result sits in an output register: the next request is taken and
// scanned while it waits, and only the update step stalls on a full register.
// The capacity register sits at byte address 0 of the APB-style port.
// Reset empties the cache, clears the access clock and sets capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_policy_unit (
   input  logic                              clock,
   input  logic                              reset,
   lfu_req_if.sink                           req_chan,
   lfu_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lfu_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import lfu_pkg::*;

   lfu_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              kind_ff;
   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] clock_ff, clock_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_ev_ff, rsp_ev_in;
   logic [DATA_W-1:0] rsp_evkey_ff, rsp_evkey_in;

   lfu_csr_type       csr_sel;
   logic              csr_write;
   logic              req_take;
   logic              rsp_free;
   logic [CMP_W-1:0]  cap_lim;
   logic [IDX_W-1:0]  rd_idx;
   lfu_entry_type     entry;
   lfu_write_type     wr;
   lfu_scan_ctl_type  scan_ctl;
   lfu_scan_type      scan;

   // Configuration port: always ready, register chosen by the word address.
   assign csr_sel   = lfu_csr_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (csr_sel == CSR_CAPACITY)) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_CAPACITY: prdata = CSR_DATA_W'(capacity_ff);
         default:      prdata = '0;
      endcase
   end

   // Capacity above the built size acts as the built size.
   assign cap_lim = (CMP_W'(capacity_ff) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                            : CMP_W'(capacity_ff);

   assign req_take = (state_ff == ST_IDLE) && req_chan.valid;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // The scan walks the store; the update step reads the hit or victim slot.
   assign rd_idx = (state_ff == ST_SCAN) ? scan_idx_ff
                 : (scan.found ? scan.found_idx : scan.min_idx);

   assign scan_ctl.clear = req_take;
   assign scan_ctl.step  = (state_ff == ST_SCAN);
   assign scan_ctl.index = scan_idx_ff;

   lfu_entry_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .wr     (wr),
      .rd     (entry)
   );

   lfu_scan_unit u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .lookup_key (key_ff),
      .entry      (entry),
      .res        (scan)
   );

   // Sequencer: next state, slot update and result build.
   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      clock_in     = clock_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evkey_in = rsp_evkey_ff;
      wr           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = scan.found;
               rsp_value_in = MISS_VALUE;
               rsp_ev_in    = 1'b0;
               rsp_evkey_in = '0;
               if (scan.found) begin
                  // Hit: bump the count and stamp; a put also takes the value.
                  wr.en    = 1'b1;
                  wr.idx   = scan.found_idx;
                  wr.key   = entry.key;
                  wr.value = (kind_ff == KIND_PUT) ? value_ff : entry.value;
                  wr.count = sat_inc(entry.count);
                  wr.stamp = clock_ff;
                  if (kind_ff == KIND_GET) begin
                     rsp_value_in = entry.value;
                  end
               end else if ((kind_ff == KIND_PUT) && (cap_lim != '0)) begin
                  // Insert into a free slot while below capacity, else evict.
                  wr.key   = key_ff;
                  wr.value = value_ff;
                  wr.count = DATA_W'(1);
                  wr.stamp = clock_ff;
                  if ((CMP_W'(occ_ff) < cap_lim) && scan.free_found) begin
                     wr.en  = 1'b1;
                     wr.idx = scan.free_idx;
                     occ_in = occ_ff + OCC_W'(1);
                  end else if (scan.min_found) begin
                     wr.en        = 1'b1;
                     wr.idx       = scan.min_idx;
                     rsp_ev_in    = 1'b1;
                     rsp_evkey_in = entry.key;
                  end
               end
               // The access clock moves on every put and on a get hit.
               if ((kind_ff == KIND_PUT) || scan.found) begin
                  clock_in = sat_inc(clock_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         clock_ff     <= '0;
         occ_ff       <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         clock_ff     <= clock_in;
         occ_ff       <= occ_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_chan.kind;
         key_ff   <= req_chan.key;
         value_ff <= req_chan.value;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_evkey_ff <= rsp_evkey_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.evicted     = rsp_ev_ff;
   assign rsp_chan.evicted_key = rsp_evkey_ff;

   // An accepted request always starts a scan from the first slot.
   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("request beat did not start a scan");

   // Occupancy never goes past the built entry count.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(occ_ff) <= CMP_W'(ENTRIES))
      else $error("occupancy exceeds entry count");

   // An eviction only happens on a miss.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.evicted) |-> !rsp_chan.hit)
      else $error("eviction reported on a hit");

   // A miss always returns the miss value.
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.hit) |-> (rsp_value_ff == MISS_VALUE))
      else $error("miss returned a stored value");

   // The result register is only loaded once the previous beat has left.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && (state_ff == ST_UPDATE)) |=>
         (state_ff == ST_UPDATE))
      else $error("update step ran over a pending result");

endmodule

FILE: test/lfu_cache_policy_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU cache policy unit testbench
// Drives get and put beats into the unit and checks every result beat against
// a cycle-free model of the cache that this bench keeps. A short table of
// directed operations covers empty lookups, extreme keys and values, updates,
// lowered, zero and oversized capacities. Random phases follow, each under its
// own capacity setting, with keys drawn from a small pool so that hits and
// evictions are frequent. Both channels stall at random, and the result side
// holds off once for a long stretch so that the unit backs up.
// ----------------------------------------------------------------------------
module lfu_cache_policy_unit_tb;
   import lfu_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DIRECTED_ROWS = 24;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 250;
   localparam int POOL_MAX      = 24;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = ENTRIES + 3;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'(CSR_CAPACITY) << 2;

   typedef struct packed {
      lfu_kind_type kind;
      logic [31:0]  key;
      logic [31:0]  value;
   } cache_op_t;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } cache_result_t;

   // One row of the directed table: an optional capacity write, the operation,
   // and a result that is typed in only where it is obvious.
   typedef struct {
      int            set_cap;
      cache_op_t     op;
      bit            typed;
      cache_result_t want;
   } directed_row_t;

   localparam cache_result_t MISS_RESULT = '{1'b0, MISS_VALUE, 1'b0, 32'h0};
   localparam cache_result_t PUT_HIT     = '{1'b1, MISS_VALUE, 1'b0, 32'h0};
   localparam cache_result_t UNTYPED     = '0;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   lfu_req_if req_chan ();
   lfu_rsp_if rsp_chan ();

   lfu_cache_policy_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Cache contents as the bench expects them.
   logic        cached_live  [ENTRIES] = '{default: 1'b0};
   logic [31:0] cached_key   [ENTRIES];
   logic [31:0] cached_data  [ENTRIES];
   logic [31:0] cached_uses  [ENTRIES];
   logic [31:0] cached_stamp [ENTRIES];
   logic [31:0] access_clock      = '0;
   int          cached_count      = 0;
   logic [4:0]  capacity_setting  = CAPACITY_RESET;

   cache_result_t pending_results [$];
   directed_row_t directed_rows [DIRECTED_ROWS];
   logic [31:0]   key_pool [POOL_MAX];
   int            pool_used;

   int          mismatch_count    = 0;
   int          results_seen      = 0;
   int          hits_seen         = 0;
   int          evictions_seen    = 0;
   int          gets_sent         = 0;
   int          puts_sent         = 0;
   int          settings_applied  = 0;
   bit          idle_enabled      = 1'b1;
   int          long_hold_cycles  = 0;
   int unsigned cycle_count       = 0;

   // Clock: 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] bump_saturating(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Applies one operation to the expected cache contents and returns the
   // result the unit must give for it.
   function automatic cache_result_t predict_access(input cache_op_t op);
      cache_result_t res;
      int found;
      int target;
      int limit;
      res = MISS_RESULT;
      found = -1;
      target = -1;
      limit = (capacity_setting > ENTRIES) ? ENTRIES : int'(capacity_setting);
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && cached_live[i] && cached_key[i] == op.key) found = i;

      if (op.kind == KIND_GET) begin
         if (found >= 0) begin
            res.hit = 1'b1;
            res.read_value = cached_data[found];
            cached_uses[found] = bump_saturating(cached_uses[found]);
            cached_stamp[found] = access_clock;
            access_clock = bump_saturating(access_clock);
         end
      end else begin
         if (found >= 0) begin
            res.hit = 1'b1;
            cached_data[found] = op.value;
            cached_uses[found] = bump_saturating(cached_uses[found]);
            cached_stamp[found] = access_clock;
         end else if (limit != 0) begin
            // Lowest free slot while there is room.
            if (cached_count < limit) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (target < 0 && !cached_live[i]) target = i;
               if (target >= 0) cached_count++;
            end
            // Otherwise the victim: fewest uses, then oldest stamp, then lowest slot.
            if (target < 0) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (cached_live[i] && (target < 0 || cached_uses[i] < cached_uses[target] ||
                      (cached_uses[i] == cached_uses[target] &&
                       cached_stamp[i] < cached_stamp[target])))
                     target = i;
               if (target >= 0) begin
                  res.evicted = 1'b1;
                  res.evicted_key = cached_key[target];
               end
            end
            if (target >= 0) begin
               cached_live[target]  = 1'b1;
               cached_key[target]   = op.key;
               cached_data[target]  = op.value;
               cached_uses[target]  = 32'd1;
               cached_stamp[target] = access_clock;
            end
         end
         access_clock = bump_saturating(access_clock);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch in %s at result %0d: expected %h, got %h", what, results_seen,
                  want, got);
   endtask

   // Result checker: each beat against the oldest expectation.
   always @(posedge clock) begin
      cache_result_t got;
      cache_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.hit, rsp_chan.read_value, rsp_chan.evicted, rsp_chan.evicted_key};
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with none expected", '0, got.read_value);
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit) report_mismatch("hit", 32'(want.hit), 32'(got.hit));
            if (got.read_value !== want.read_value)
               report_mismatch("read_value", want.read_value, got.read_value);
            if (got.evicted !== want.evicted)
               report_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
            if (got.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", want.evicted_key, got.evicted_key);
         end
         results_seen++;
         if (got.hit === 1'b1) hits_seen++;
         if (got.evicted === 1'b1) evictions_seen++;
      end
   end

   // Result side: random stall bursts, and one long hold-off when asked for.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offers one operation and waits for its beat. Valid stays high on return
   // so that back-to-back operations need no second assignment in one step.
   task automatic send_op(input cache_op_t op, input bit typed, input cache_result_t want);
      cache_result_t predicted;
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind  <= op.kind;
      req_chan.key   <= op.key;
      req_chan.value <= op.value;
      do @(posedge clock); while (!req_chan.ready);
      predicted = predict_access(op);
      pending_results.push_back(typed ? want : predicted);
      if (op.kind == KIND_GET) gets_sent++;
      else puts_sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected result has arrived.
   task automatic finish_outstanding();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // One register transfer; psel stays high on return.
   task automatic csr_transfer(input bit is_write, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic set_capacity(input int cap);
      logic [31:0] readback;
      finish_outstanding();
      csr_transfer(1'b1, 32'(cap), readback);
      capacity_setting = 5'(cap);
      csr_transfer(1'b0, '0, readback);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== 32'(capacity_setting))
         report_mismatch("capacity readback", 32'(capacity_setting), readback);
      settings_applied++;
   endtask

   // Key pool for one phase: a little larger than the capacity, with the
   // extreme keys mixed in now and then.
   task automatic fill_key_pool(input int cap);
      int held;
      held = (cap > ENTRIES) ? ENTRIES : cap;
      pool_used = held + $urandom_range(1, 6);
      for (int i = 0; i < pool_used; i++) begin
         case ($urandom_range(0, 11))
            0:       key_pool[i] = 32'h8000_0000;
            1:       key_pool[i] = 32'h7FFF_FFFF;
            2:       key_pool[i] = 32'h0000_0000;
            3:       key_pool[i] = 32'hFFFF_FFFF;
            default: key_pool[i] = $urandom;
         endcase
      end
   endtask

   function automatic cache_op_t random_op();
      cache_op_t op;
      op.kind  = ($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET;
      op.key   = ($urandom_range(0, 9) == 0) ? $urandom
                                             : key_pool[$urandom_range(0, pool_used - 1)];
      op.value = $urandom;
      return op;
   endfunction

   // Stimulus.
   initial begin
      logic [31:0] reset_capacity;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_chan.valid = 1'b0;
      req_chan.kind  = KIND_GET;
      req_chan.key   = '0;
      req_chan.value = '0;

      directed_rows = '{
         '{-1, '{KIND_GET, 32'h0000_0005, 32'h0000_0000}, 1'b1, MISS_RESULT},
         '{-1, '{KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1, MISS_RESULT},
         '{-1, '{KIND_GET, 32'h8000_0000, 32'h0000_0000}, 1'b1,
               '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
         '{-1, '{KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, MISS_RESULT},
         '{-1, '{KIND_PUT, 32'h7FFF_FFFF, 32'h0000_0000}, 1'b1, PUT_HIT},
         '{-1, '{KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
               '{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
         '{-1, '{KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0, UNTYPED},
         '{-1, '{KIND_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5}, 1'b0, UNTYPED},
         '{-1, '{KIND_GET, 32'h0000_0000, 32'h0000_0000}, 1'b0, UNTYPED},
         // Capacity lowered below the held entries: puts evict and replace.
         '{ 2, '{KIND_PUT, 32'h0000_0064, 32'h0000_0001}, 1'b0, UNTYPED},
         '{-1, '{KIND_PUT, 32'h0000_0065, 32'h0000_0002}, 1'b0, UNTYPED},
         '{-1, '{KIND_GET, 32'h0000_0064, 32'h0000_0000}, 1'b0, UNTYPED},
         '{-1, '{KIND_GET, 32'h0000_0000, 32'h0000_0000}, 1'b0, UNTYPED},
         // Zero capacity: a new key is neither stored nor makes room.
         '{ 0, '{KIND_PUT, 32'h0000_00C8, 32'h0000_0003}, 1'b1, MISS_RESULT},
         '{-1, '{KIND_GET, 32'h0000_00C8, 32'h0000_0000}, 1'b1, MISS_RESULT},
         '{-1, '{KIND_PUT, 32'h0000_0064, 32'h0000_0004}, 1'b0, UNTYPED},
         // Single entry.
         '{ 1, '{KIND_PUT, 32'h0000_012C, 32'h1234_5678}, 1'b0, UNTYPED},
         '{-1, '{KIND_PUT, 32'h0000_012D, 32'h8765_4321}, 1'b0, UNTYPED},
         '{-1, '{KIND_GET, 32'h0000_012D, 32'h0000_0000}, 1'b0, UNTYPED},
         // Capacity above the built size acts as the built size.
         '{31, '{KIND_PUT, 32'h0000_0190, 32'hFFFF_0000}, 1'b0, UNTYPED},
         '{-1, '{KIND_PUT, 32'h0000_0191, 32'h0000_FFFF}, 1'b0, UNTYPED},
         '{-1, '{KIND_GET, 32'h0000_0190, 32'h0000_0000}, 1'b0, UNTYPED},
         '{-1, '{KIND_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA}, 1'b0, UNTYPED},
         '{16, '{KIND_GET, 32'h0000_0191, 32'h0000_0000}, 1'b0, UNTYPED}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Capacity after reset.
      csr_transfer(1'b0, '0, reset_capacity);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (reset_capacity !== 32'(CAPACITY_RESET))
         report_mismatch("capacity after reset", 32'(CAPACITY_RESET), reset_capacity);

      // Directed table.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_cap >= 0) set_capacity(directed_rows[r].set_cap);
         send_op(directed_rows[r].op, directed_rows[r].typed, directed_rows[r].want);
      end

      // Random phases, one capacity setting each; the last runs without stalls.
      for (int p = 0; p < PHASES; p++) begin
         int cap;
         case (p)
            0:       cap = 16;
            1:       cap = 4;
            2:       cap = 31;
            3:       cap = 0;
            4:       cap = 1;
            5:       cap = 17;
            6:       cap = $urandom_range(0, 31);
            default: cap = 16;
         endcase
         set_capacity(cap);
         idle_enabled = (p != 2) && (p != PHASES - 1);
         fill_key_pool(cap);
         if (p == 1) long_hold_cycles = LONG_HOLD;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Sender pauses mid-phase until the unit has answered everything.
            if (p == 5 && n == PHASE_ITEMS / 2) finish_outstanding();
            send_op(random_op(), 1'b0, UNTYPED);
         end
      end

      finish_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never returned", pending_results.size(), '0);

      $display("Covered %0d gets and %0d puts under %0d capacity settings",
               gets_sent, puts_sent, settings_applied);
      $display("(zero, one, lowered, oversized); results checked: %0d, of which %0d hits",
               results_seen, hits_seen);
      $display("and %0d evictions; mismatches: %0d.", evictions_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
